>>> sv/signed_int_to_decimal_ascii_core_defines.svh
// assertion macros for the signed integer to ascii decimal core
// used by the checker module, no other dependencies
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

// property that holds at every clock edge outside reset
`define SITDA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next cycle
`define SITDA_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error(msg);

`endif

>>> sv/sitda_pkg.sv
// shared types, constants and conversion functions for the ascii decimal core
// no dependencies
package sitda_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int MAX_DIGITS  = 10;
	localparam int NUM_STAGES  = 4;
	localparam int STEPS       = (VALUE_WIDTH + NUM_STAGES - 1) / NUM_STAGES;
	localparam int PAD_W       = NUM_STAGES * STEPS;
	localparam int BCD_W       = 4 * MAX_DIGITS;
	localparam int IDX_W       = $clog2(MAX_DIGITS);
	localparam int CHAR_W      = 6;

	localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);

	typedef struct packed {
		logic [PAD_W-1:0] mag;
		logic [BCD_W-1:0] bcd;
		logic             neg;
		logic             ovf;
	} conv_t;

	// one shift-add-3 step, top bit of the result is the carry out of the top digit
	function automatic logic [BCD_W:0] dabble_step(input logic [BCD_W-1:0] bcd,
		input logic in_bit);
		logic [BCD_W-1:0] adj;
		logic [3:0]       dig;
		for (int d = 0; d < MAX_DIGITS; d++) begin
			dig = bcd[4*d +: 4];
			adj[4*d +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
		end
		return {adj, in_bit};
	endfunction

	// steps for one pipeline stage
	function automatic conv_t conv_stage(input conv_t c);
		conv_t            r;
		logic [BCD_W:0]   sh;
		r = c;
		for (int i = 0; i < STEPS; i++) begin
			sh = dabble_step(r.bcd, r.mag[PAD_W-1]);
			r.bcd = sh[BCD_W-1:0];
			r.ovf = r.ovf | sh[BCD_W];
			r.mag = r.mag << 1;
		end
		return r;
	endfunction

endpackage

>>> sv/signed_int_to_decimal_ascii_core.sv
// a value passes stage 1, the double dabble stages and the digit-count stage before the
// output serializer loads it; the serializer sends one character per cycle while out_ready
// is high, 1 to 11 per number (its text length); the conversion pipeline takes a value every
// cycle while it is not full and buffers up to six numbers while the serializer is busy
// reset: arst_n clears all valid bits and the serializer, data registers are not reset
module signed_int_to_decimal_ascii_core
	import sitda_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic        [CHAR_W-1:0]      character,
	output logic                          last
);

	localparam int LAST = NUM_STAGES + 1;

	logic  vld_s [1:LAST+1];
	logic  rdy_s [1:LAST+1];
	conv_t conv_s [1:LAST];

	logic [BCD_W-1:0] bcd_fin_s;
	logic             neg_fin_s;
	logic [IDX_W-1:0] idx_fin_s;

	logic [BCD_W-1:0] bcd_q;
	logic             neg_q;
	logic [IDX_W-1:0] idx_q;
	logic             busy_q;

	logic [VALUE_WIDTH-1:0] mag_in;
	logic [IDX_W-1:0]       top_idx;
	logic                   load_rdy;
	logic                   final_beat;

	assign in_ready = rdy_s[1];

	// magnitude as unsigned, so the most negative value comes out as 2^(w-1)
	assign mag_in = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;

	// stage 1: sign and magnitude
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[1] <= 1'b0;
		end else if (rdy_s[1]) begin
			vld_s[1] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s[1] && in_valid) begin
			conv_s[1].mag <= PAD_W'(mag_in);
			conv_s[1].bcd <= '0;
			conv_s[1].neg <= value[VALUE_WIDTH-1];
			conv_s[1].ovf <= 1'b0;
		end
	end

	// double dabble stages
	for (genvar k = 2; k <= LAST; k++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy_s[k]) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy_s[k] && vld_s[k-1]) begin
				conv_s[k] <= conv_stage(conv_s[k-1]);
			end
		end
	end

	for (genvar k = 1; k <= LAST; k++) begin : g_rdy
		assign rdy_s[k] = !vld_s[k] || rdy_s[k+1];
	end
	assign rdy_s[LAST+1] = !vld_s[LAST+1] || load_rdy;

	// index of the leading digit, all digits kept when digits were dropped
	always_comb begin
		top_idx = '0;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (conv_s[LAST].bcd[4*i +: 4] != 4'd0) begin
				top_idx = IDX_W'(i);
			end
		end
		if (conv_s[LAST].ovf) begin
			top_idx = IDX_W'(MAX_DIGITS - 1);
		end
	end

	// final stage: digit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[LAST+1] <= 1'b0;
		end else if (rdy_s[LAST+1]) begin
			vld_s[LAST+1] <= vld_s[LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s[LAST+1] && vld_s[LAST]) begin
			bcd_fin_s <= conv_s[LAST].bcd;
			neg_fin_s <= conv_s[LAST].neg;
			idx_fin_s <= top_idx;
		end
	end

	// output serializer
	assign final_beat = !neg_q && (idx_q == '0);
	assign load_rdy   = !busy_q || (out_ready && final_beat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			neg_q  <= 1'b0;
			idx_q  <= '0;
		end else if (load_rdy) begin
			busy_q <= vld_s[LAST+1];
			if (vld_s[LAST+1]) begin
				neg_q <= neg_fin_s;
				idx_q <= idx_fin_s;
			end
		end else if (out_ready) begin
			if (neg_q) begin
				neg_q <= 1'b0;
			end else begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_rdy && vld_s[LAST+1]) begin
			bcd_q <= bcd_fin_s;
		end
	end

	assign out_valid = busy_q;
	assign last      = final_beat;
	assign character = neg_q ? CHAR_MINUS : CHAR_ZERO + CHAR_W'(bcd_q[idx_q*4 +: 4]);

endmodule

>>> sv/sitda_checker.sv
// port-level checks for the ascii decimal core, bound to the top level
// depends on sitda_pkg and signed_int_to_decimal_ascii_core_defines.svh
`include "signed_int_to_decimal_ascii_core_defines.svh"

module sitda_checker
	import sitda_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [CHAR_W-1:0] character,
	input logic              last
);

	logic            is_minus;
	logic            is_digit;
	logic            stalled;
	logic            mid_beat;
	logic [CHAR_W:0] beat;

	assign is_minus = character == CHAR_MINUS;
	assign is_digit = character >= CHAR_ZERO && character <= CHAR_ZERO + CHAR_W'(9);
	assign stalled  = out_valid && !out_ready;
	assign mid_beat = out_valid && out_ready && !last;
	assign beat     = {character, last};

	`SITDA_ASSERT_NEXT(a_out_hold, clk, arst_n, stalled, out_valid && $stable(beat), "beat not held")
	`SITDA_ASSERT(a_char_range, clk, arst_n, !out_valid || is_minus || is_digit, "bad character")
	`SITDA_ASSERT(a_minus_not_last, clk, arst_n, !(out_valid && is_minus && last), "minus marked last")
	`SITDA_ASSERT_NEXT(a_text_unbroken, clk, arst_n, mid_beat, out_valid, "gap inside a text")

endmodule

bind signed_int_to_decimal_ascii_core sitda_checker u_sitda_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.character (character),
	.last      (last)
);
